[hw/rtl/lpp_pkg.sv]
// Shared types and constants for the lidar point to pixel projection block.
// Used by the top level, the pipelined divider and the port checker.
// No dependencies.
package lpp_pkg;

   // Request and result field widths fixed by the interface.
   localparam int POINT_BITS    = 24;
   localparam int REQ_DATA_BITS = 3 * POINT_BITS;
   localparam int LEVEL_BITS    = 8;

   // Camera axis operands: -y and -z - offset need one bit more than a point.
   localparam int AXIS_BITS = POINT_BITS + 1;

   // Configuration register widths.
   localparam int ROW_BITS    = 63;
   localparam int SIZE_BITS   = 13;
   localparam int OFFSET_BITS = 17;

   // Configuration port geometry: 64-bit data, registers at 8-byte steps.
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_ADDR_BITS = 6;
   localparam int CSR_IDX_LSB   = 3;

   // Register reset values.
   localparam logic [SIZE_BITS-1:0]   WIDTH_RESET  = 13'd640;
   localparam logic [SIZE_BITS-1:0]   HEIGHT_RESET = 13'd480;
   localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = 17'd1966;

   // Distance colour: d = 255 * x / 5 metres. With q = (255 * x) >> 16, d = q / 5,
   // done as q * 13108 >> 16, which is exact for q below 1280. At or above 1280
   // the colour saturates anyway.
   localparam int                       COLOUR_Q_BITS  = 15;
   localparam int                       COLOUR_QS_BITS = 11;
   localparam int                       RECIP_BITS     = 14;
   localparam int                       RECIP_SHIFT    = 16;
   localparam logic [COLOUR_Q_BITS-1:0] COLOUR_SAT_Q   = 15'd1280;
   localparam logic [RECIP_BITS-1:0]    COLOUR_RECIP   = 14'd13108;
   localparam logic [LEVEL_BITS-1:0]    LEVEL_MAX      = 8'd255;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      REG_ROW_ZERO      = 3'd0,
      REG_ROW_ONE       = 3'd1,
      REG_ROW_TWO       = 3'd2,
      REG_IMAGE_WIDTH   = 3'd3,
      REG_IMAGE_HEIGHT  = 3'd4,
      REG_HEIGHT_OFFSET = 3'd5
   } csr_reg_type;

   // Per-point sideband that rides along with the division.
   typedef struct packed {
      logic                  col_ok;
      logic                  row_ok;
      logic [LEVEL_BITS-1:0] red;
      logic [LEVEL_BITS-1:0] green;
      logic                  last;
   } lpp_side_type;

endpackage

[hw/rtl/lpp_divider.sv]
// Pipelined restoring divider producing column and row quotients together.
// One quotient bit per stage, with valid bits and per-stage stall.
// Depends on lpp_pkg for the sideband struct.
module lpp_divider #(
   parameter int QUO_BITS = 12,
   parameter int DIV_BITS = 59
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [DIV_BITS-1:0]   in_num_col,
   input  logic [DIV_BITS-1:0]   in_num_row,
   input  logic [DIV_BITS-1:0]   in_den,
   input  lpp_pkg::lpp_side_type in_side,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [QUO_BITS-1:0]   out_quo_col,
   output logic [QUO_BITS-1:0]   out_quo_row,
   output lpp_pkg::lpp_side_type out_side
);
   import lpp_pkg::*;

   // Stage registers, one entry per quotient bit.
   logic                vld_ff     [QUO_BITS];
   logic [DIV_BITS-1:0] rem_col_ff [QUO_BITS];
   logic [DIV_BITS-1:0] rem_row_ff [QUO_BITS];
   logic [DIV_BITS-1:0] den_ff     [QUO_BITS];
   logic [QUO_BITS-1:0] quo_col_ff [QUO_BITS];
   logic [QUO_BITS-1:0] quo_row_ff [QUO_BITS];
   lpp_side_type        side_ff    [QUO_BITS];

   // A stage may load when it is empty or its content moves on.
   logic [QUO_BITS:0] stage_en;

   assign stage_en[QUO_BITS] = out_ready;
   assign in_ready           = stage_en[0];

   for (genvar i = 0; i < QUO_BITS; i++) begin : g_stage
      logic                vld_prev;
      logic [DIV_BITS-1:0] rem_col_prev;
      logic [DIV_BITS-1:0] rem_row_prev;
      logic [DIV_BITS-1:0] den_prev;
      logic [QUO_BITS-1:0] quo_col_prev;
      logic [QUO_BITS-1:0] quo_row_prev;
      lpp_side_type        side_prev;
      logic [DIV_BITS-1:0] den_shift;
      logic                bit_col;
      logic                bit_row;
      logic [DIV_BITS-1:0] rem_col_in;
      logic [DIV_BITS-1:0] rem_row_in;
      logic [QUO_BITS-1:0] quo_col_in;
      logic [QUO_BITS-1:0] quo_row_in;

      // Operands come from the divider input or from the stage before.
      if (i == 0) begin : g_first
         assign vld_prev     = in_valid;
         assign rem_col_prev = in_num_col;
         assign rem_row_prev = in_num_row;
         assign den_prev     = in_den;
         assign quo_col_prev = '0;
         assign quo_row_prev = '0;
         assign side_prev    = in_side;
      end else begin : g_next
         assign vld_prev     = vld_ff[i-1];
         assign rem_col_prev = rem_col_ff[i-1];
         assign rem_row_prev = rem_row_ff[i-1];
         assign den_prev     = den_ff[i-1];
         assign quo_col_prev = quo_col_ff[i-1];
         assign quo_row_prev = quo_row_ff[i-1];
         assign side_prev    = side_ff[i-1];
      end

      assign stage_en[i] = !vld_ff[i] || stage_en[i+1];

      // Decide one quotient bit: subtract the divisor aligned to this bit if it fits.
      always_comb begin
         den_shift  = den_prev << (QUO_BITS - 1 - i);
         bit_col    = rem_col_prev >= den_shift;
         bit_row    = rem_row_prev >= den_shift;
         rem_col_in = bit_col ? rem_col_prev - den_shift : rem_col_prev;
         rem_row_in = bit_row ? rem_row_prev - den_shift : rem_row_prev;
         quo_col_in = {quo_col_prev[QUO_BITS-2:0], bit_col};
         quo_row_in = {quo_row_prev[QUO_BITS-2:0], bit_row};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (stage_en[i]) begin
            vld_ff[i] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[i]) begin
            rem_col_ff[i] <= rem_col_in;
            rem_row_ff[i] <= rem_row_in;
            den_ff[i]     <= den_prev;
            quo_col_ff[i] <= quo_col_in;
            quo_row_ff[i] <= quo_row_in;
            side_ff[i]    <= side_prev;
         end
      end
   end

   assign out_valid   = vld_ff[QUO_BITS-1];
   assign out_quo_col = quo_col_ff[QUO_BITS-1];
   assign out_quo_row = quo_row_ff[QUO_BITS-1];
   assign out_side    = side_ff[QUO_BITS-1];

endmodule

[hw/rtl/lidar_point_to_pixel_projection.sv]
// Lidar point to pixel projection: top level with configuration registers,
// axis remap, matrix product, range checks and output register.
// Depends on lpp_pkg and lpp_divider.
//
// Usage:
//   Requests carry one lidar point (x, y, z, signed Q8.16 metres) on req_tdata
//   and the end-of-scan mark on req_tlast. Each request gives exactly one result
//   on rsp_: rsp_tuser is the in-view flag, rsp_tdata holds column, row, red
//   and green levels (all zero when the point is out of view), rsp_tlast copies
//   the end-of-scan mark.
//   Throughput is one request per clock while the receiver does not stall. The
//   pipeline has four arithmetic stages (remap, nine multipliers, row sums,
//   range checks), one divider stage per pixel bit, and the output register.
//   The divider depth follows PIXEL_BITS, since each stage settles one
//   quotient bit of the column and the row.
//   Every stage holds its own valid bit. When the receiver stalls, the output
//   register holds its result and upstream stages keep filling until they are
//   all occupied; only then does req_tready drop. Nothing is lost or repeated.
//   Reset empties the pipeline and loads the register defaults (zero matrix,
//   640 x 480 image, 0.03 m height offset). The user must write registers via
//   the csr_ port at 8-byte steps only while no request is in flight; unenforced.
module lidar_point_to_pixel_projection #(
   parameter int PIXEL_BITS = 12,
   parameter int COEF_BITS  = 21
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // point_x [23:0], point_y [47:24], point_z [71:48].
   input  logic [lpp_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  logic                               req_tlast,
   // Result channel.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // pixel_col, pixel_row, red_level, green_level from bit 0 up, zero padded.
   output logic [((2*PIXEL_BITS+2*lpp_pkg::LEVEL_BITS+7)/8)*8-1:0] rsp_tdata,
   // in_view.
   output logic                               rsp_tuser,
   output logic                               rsp_tlast,
   // Configuration port.
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [lpp_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [lpp_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [lpp_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);
   import lpp_pkg::*;

   localparam int PROD_BITS     = COEF_BITS + AXIS_BITS;
   localparam int DOT_BITS      = PROD_BITS + 2;
   localparam int DIV_BITS      = DOT_BITS - 1 + PIXEL_BITS;
   localparam int RSP_DATA_BITS = ((2 * PIXEL_BITS + 2 * LEVEL_BITS + 7) / 8) * 8;
   localparam int CMP_BITS      = 32;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [ROW_BITS-1:0]    row_ff [3];
   logic [SIZE_BITS-1:0]   width_ff;
   logic [SIZE_BITS-1:0]   height_ff;
   logic [OFFSET_BITS-1:0] offset_ff;
   csr_reg_type            csr_idx;
   logic                   csr_wr;

   assign csr_idx    = csr_reg_type'(csr_paddr[CSR_ADDR_BITS-1:CSR_IDX_LSB]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   // Register writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= '0;
         row_ff[1] <= '0;
         row_ff[2] <= '0;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         offset_ff <= OFFSET_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_ROW_ZERO:      row_ff[0] <= csr_pwdata[ROW_BITS-1:0];
            REG_ROW_ONE:       row_ff[1] <= csr_pwdata[ROW_BITS-1:0];
            REG_ROW_TWO:       row_ff[2] <= csr_pwdata[ROW_BITS-1:0];
            REG_IMAGE_WIDTH:   width_ff  <= csr_pwdata[SIZE_BITS-1:0];
            REG_IMAGE_HEIGHT:  height_ff <= csr_pwdata[SIZE_BITS-1:0];
            REG_HEIGHT_OFFSET: offset_ff <= csr_pwdata[OFFSET_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Register read back.
   always_comb begin
      unique case (csr_idx)
         REG_ROW_ZERO:      csr_prdata = CSR_DATA_BITS'(row_ff[0]);
         REG_ROW_ONE:       csr_prdata = CSR_DATA_BITS'(row_ff[1]);
         REG_ROW_TWO:       csr_prdata = CSR_DATA_BITS'(row_ff[2]);
         REG_IMAGE_WIDTH:   csr_prdata = CSR_DATA_BITS'(width_ff);
         REG_IMAGE_HEIGHT:  csr_prdata = CSR_DATA_BITS'(height_ff);
         REG_HEIGHT_OFFSET: csr_prdata = CSR_DATA_BITS'(offset_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Stage enables: a stage loads when empty or when its content moves on.
   // ------------------------------------------------------------------
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic s1_en, s2_en, s3_en, s4_en;
   logic div_in_ready;
   logic div_out_valid;
   logic out_en;
   logic rsp_vld_ff;

   assign out_en     = !rsp_vld_ff || rsp_tready;
   assign s4_en      = !s4_vld_ff || div_in_ready;
   assign s3_en      = !s3_vld_ff || s4_en;
   assign s2_en      = !s2_vld_ff || s3_en;
   assign s1_en      = !s1_vld_ff || s2_en;
   assign req_tready = s1_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (s1_en) begin
            s1_vld_ff <= req_tvalid;
         end
         if (s2_en) begin
            s2_vld_ff <= s1_vld_ff;
         end
         if (s3_en) begin
            s3_vld_ff <= s2_vld_ff;
         end
         if (s4_en) begin
            s4_vld_ff <= s3_vld_ff;
         end
         if (out_en) begin
            rsp_vld_ff <= div_out_valid;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: remap to camera axes and start the distance colour.
   // ------------------------------------------------------------------
   logic signed [POINT_BITS-1:0]     pt_x, pt_y, pt_z;
   logic signed [OFFSET_BITS-1:0]    offset_s;
   logic signed [AXIS_BITS-1:0]      axis_in [3];
   logic [31:0]                      scaled_x;
   logic [COLOUR_Q_BITS-1:0]         colour_q;
   logic signed [AXIS_BITS-1:0]      axis_ff [3];
   logic [COLOUR_QS_BITS-1:0]        s1_q_ff;
   logic                             s1_pos_ff, s1_sat_ff, s1_last_ff;

   assign pt_x     = req_tdata[POINT_BITS-1:0];
   assign pt_y     = req_tdata[2*POINT_BITS-1:POINT_BITS];
   assign pt_z     = req_tdata[3*POINT_BITS-1:2*POINT_BITS];
   assign offset_s = offset_ff;

   always_comb begin
      axis_in[0] = -AXIS_BITS'(pt_y);
      axis_in[1] = -AXIS_BITS'(pt_z) - AXIS_BITS'(offset_s);
      axis_in[2] = AXIS_BITS'(pt_x);
      // 255 * x as x * 256 - x; only the positive case is kept further on.
      scaled_x   = {pt_x, 8'h00} - 32'(pt_x);
      colour_q   = scaled_x[30:16];
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         axis_ff    <= axis_in;
         s1_q_ff    <= colour_q[COLOUR_QS_BITS-1:0];
         s1_sat_ff  <= colour_q >= COLOUR_SAT_Q;
         s1_pos_ff  <= !pt_x[POINT_BITS-1] && (pt_x != '0);
         s1_last_ff <= req_tlast;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: nine coefficient products and the divide by five.
   // ------------------------------------------------------------------
   logic signed [COEF_BITS-1:0]         coef [3][3];
   logic signed [PROD_BITS-1:0]         prod_in [3][3];
   logic [COLOUR_QS_BITS+RECIP_BITS-1:0] colour_prod;
   logic signed [PROD_BITS-1:0]         prod_ff [3][3];
   logic [LEVEL_BITS-1:0]               s2_d_ff;
   logic                                s2_pos_ff, s2_sat_ff, s2_last_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            coef[r][k]    = row_ff[r][k*COEF_BITS +: COEF_BITS];
            prod_in[r][k] = PROD_BITS'(coef[r][k]) * PROD_BITS'(axis_ff[k]);
         end
      end
      colour_prod = (COLOUR_QS_BITS+RECIP_BITS)'(s1_q_ff) *
                    (COLOUR_QS_BITS+RECIP_BITS)'(COLOUR_RECIP);
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         prod_ff    <= prod_in;
         s2_d_ff    <= colour_prod[RECIP_SHIFT +: LEVEL_BITS];
         s2_pos_ff  <= s1_pos_ff;
         s2_sat_ff  <= s1_sat_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: row sums and the saturated colour levels.
   // ------------------------------------------------------------------
   logic signed [DOT_BITS-1:0] dot_in [3];
   logic [LEVEL_BITS-1:0]      red_in, green_in;
   logic signed [DOT_BITS-1:0] dot_ff [3];
   logic [LEVEL_BITS-1:0]      s3_red_ff, s3_green_ff;
   logic                       s3_last_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         dot_in[r] = DOT_BITS'(prod_ff[r][0]) + DOT_BITS'(prod_ff[r][1]) +
                     DOT_BITS'(prod_ff[r][2]);
      end
      // Zero or negative x gives full red; far points saturate to full green.
      if (!s2_pos_ff) begin
         green_in = '0;
         red_in   = LEVEL_MAX;
      end else if (s2_sat_ff) begin
         green_in = LEVEL_MAX;
         red_in   = '0;
      end else begin
         green_in = s2_d_ff;
         red_in   = LEVEL_MAX - s2_d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_en) begin
         dot_ff      <= dot_in;
         s3_red_ff   <= red_in;
         s3_green_ff <= green_in;
         s3_last_ff  <= s2_last_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: depth sign and quotient range checks, division operands.
   // A quotient in [0, 2^PIXEL_BITS) needs -P2 < P < P2 * 2^PIXEL_BITS;
   // a negative product above -P2 truncates to zero and gets a zero numerator.
   // ------------------------------------------------------------------
   logic                      depth_pos;
   logic [DIV_BITS-1:0]       den_in;
   logic [DIV_BITS-1:0]       den_limit;
   logic signed [DOT_BITS:0]  low_sum [2];
   logic                      axis_ok [2];
   logic [DIV_BITS-1:0]       num_in [2];
   logic [DIV_BITS-1:0]       num_ff [2];
   logic [DIV_BITS-1:0]       den_ff;
   lpp_side_type              s4_side_ff;
   lpp_side_type              side_in;

   always_comb begin
      depth_pos = !dot_ff[2][DOT_BITS-1] && (dot_ff[2] != '0);
      den_in    = DIV_BITS'(dot_ff[2][DOT_BITS-2:0]);
      den_limit = den_in << PIXEL_BITS;
      for (int r = 0; r < 2; r++) begin
         low_sum[r] = (DOT_BITS+1)'(dot_ff[r]) + (DOT_BITS+1)'(dot_ff[2]);
         if (dot_ff[r][DOT_BITS-1]) begin
            axis_ok[r] = depth_pos && !low_sum[r][DOT_BITS] && (low_sum[r] != '0);
            num_in[r]  = '0;
         end else begin
            num_in[r]  = DIV_BITS'(dot_ff[r][DOT_BITS-2:0]);
            axis_ok[r] = depth_pos && (num_in[r] < den_limit);
         end
      end
      side_in.col_ok = axis_ok[0];
      side_in.row_ok = axis_ok[1];
      side_in.red    = s3_red_ff;
      side_in.green  = s3_green_ff;
      side_in.last   = s3_last_ff;
   end

   always_ff @(posedge clock) begin
      if (s4_en) begin
         num_ff     <= num_in;
         den_ff     <= den_in;
         s4_side_ff <= side_in;
      end
   end

   // ------------------------------------------------------------------
   // Division: one quotient bit per stage for column and row.
   // ------------------------------------------------------------------
   logic [PIXEL_BITS-1:0] quo_col, quo_row;
   lpp_side_type          div_side;

   lpp_divider #(
      .QUO_BITS (PIXEL_BITS),
      .DIV_BITS (DIV_BITS)
   ) u_divider (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s4_vld_ff),
      .in_ready    (div_in_ready),
      .in_num_col  (num_ff[0]),
      .in_num_row  (num_ff[1]),
      .in_den      (den_ff),
      .in_side     (s4_side_ff),
      .out_valid   (div_out_valid),
      .out_ready   (out_en),
      .out_quo_col (quo_col),
      .out_quo_row (quo_row),
      .out_side    (div_side)
   );

   // ------------------------------------------------------------------
   // Output register: image bounds and zeroing of out-of-view results.
   // ------------------------------------------------------------------
   logic                  in_view_in;
   logic                  in_view_ff;
   logic [PIXEL_BITS-1:0] col_ff, row_pix_ff;
   logic [LEVEL_BITS-1:0] red_ff, green_ff;
   logic                  last_ff;

   assign in_view_in = div_side.col_ok && div_side.row_ok &&
                       (CMP_BITS'(quo_col) < CMP_BITS'(width_ff)) &&
                       (CMP_BITS'(quo_row) < CMP_BITS'(height_ff));

   always_ff @(posedge clock) begin
      if (out_en) begin
         in_view_ff <= in_view_in;
         col_ff     <= in_view_in ? quo_col : '0;
         row_pix_ff <= in_view_in ? quo_row : '0;
         red_ff     <= in_view_in ? div_side.red : '0;
         green_ff   <= in_view_in ? div_side.green : '0;
         last_ff    <= div_side.last;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({green_ff, red_ff, row_pix_ff, col_ff});
   assign rsp_tuser  = in_view_ff;
   assign rsp_tlast  = last_ff;

endmodule

[hw/rtl/lpp_checker.sv]
// Port-level checker for the lidar point to pixel projection block,
// bound to the top level. Depends on lpp_pkg for field widths.
module lpp_checker #(
   parameter int PIXEL_BITS = 12
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [((2*PIXEL_BITS+2*lpp_pkg::LEVEL_BITS+7)/8)*8-1:0] rsp_tdata,
   input logic                              rsp_tuser,
   input logic                              rsp_tlast
);
   import lpp_pkg::*;

   localparam int SUM_BITS = LEVEL_BITS + 1;

   logic [LEVEL_BITS-1:0] red_lvl, green_lvl;

   assign red_lvl   = rsp_tdata[2*PIXEL_BITS +: LEVEL_BITS];
   assign green_lvl = rsp_tdata[2*PIXEL_BITS+LEVEL_BITS +: LEVEL_BITS];

   // The pipeline is empty right after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A stalled result holds its payload.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Requests are refused only when every stage is full behind a stalled result.
   a_ready_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request refused without a stalled result");

   // Out-of-view results carry an all-zero payload.
   a_out_of_view_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("out-of-view result carries data");

   // The two colour levels of a point in view always complement each other.
   a_colour_complement: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         (SUM_BITS'(red_lvl) + SUM_BITS'(green_lvl)) == SUM_BITS'(LEVEL_MAX))
      else $error("red and green levels do not sum to full scale");

endmodule

bind lidar_point_to_pixel_projection lpp_checker #(
   .PIXEL_BITS (PIXEL_BITS)
) u_lpp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
